### rtl/arf_pkg.sv
// Shared types, codes and helpers for the agent registration block.
// Used by arf_if.sv, arf_core.sv and agent_registration_fsm.sv.
package arf_pkg;

  localparam int ADDR_W = 64;
  localparam int PORT_W = 16;
  localparam int XID_W  = 16;
  localparam int TIME_W = 16;
  localparam int CMD_W  = 3;
  localparam int SEND_W = 2;
  localparam int TMR_W  = 2;
  localparam int STATE_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CMD_W-1:0] CMD_AA      = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DA      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ACK     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MOVE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXPIRE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd5;

  localparam logic [SEND_W-1:0] SEND_NONE  = 2'd0;
  localparam logic [SEND_W-1:0] SEND_REG   = 2'd1;
  localparam logic [SEND_W-1:0] SEND_DEREG = 2'd2;

  localparam logic [TMR_W-1:0] TMR_LEAVE = 2'd0;
  localparam logic [TMR_W-1:0] TMR_START = 2'd1;
  localparam logic [TMR_W-1:0] TMR_STOP  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFETIME       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AGENT_IS_AA    = 2'd3;

  localparam logic [STATE_W-1:0] CODE_IDLE   = 2'd0;
  localparam logic [STATE_W-1:0] CODE_WREG   = 2'd1;
  localparam logic [STATE_W-1:0] CODE_DONE   = 2'd2;
  localparam logic [STATE_W-1:0] CODE_WUNREG = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_WREG   = 4'b0010,
    PH_DONE   = 4'b0100,
    PH_WUNREG = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [TIME_W-1:0] retry_interval;
    logic [TIME_W-1:0] retry_limit;
    logic [TIME_W-1:0] lifetime;
    logic              agent_is_aa;
  } arf_cfg_t;

  typedef struct packed {
    phase_t            phase;
    logic [ADDR_W-1:0] agent_high;
    logic [ADDR_W-1:0] agent_low;
    logic [PORT_W-1:0] agent_port;
    logic [ADDR_W-1:0] next_high;
    logic [ADDR_W-1:0] next_low;
    logic [PORT_W-1:0] next_port;
    logic              next_waiting;
    logic [XID_W-1:0]  current_xid;
    logic [TIME_W-1:0] elapsed_retry;
    logic              release_pending;
    logic              timer_uses_retry;
  } arf_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] addr_high;
    logic [ADDR_W-1:0] addr_low;
    logic [PORT_W-1:0] addr_port;
    logic [XID_W-1:0]  ack_xid;
    logic [XID_W-1:0]  fresh_xid;
  } arf_event_t;

  typedef struct packed {
    logic [SEND_W-1:0]  send_kind;
    logic [ADDR_W-1:0]  dest_high;
    logic [ADDR_W-1:0]  dest_low;
    logic [PORT_W-1:0]  dest_port;
    logic [XID_W-1:0]   send_xid;
    logic [TMR_W-1:0]   timer_action;
    logic [TIME_W-1:0]  timer_interval;
    logic               release_notice;
    logic [STATE_W-1:0] conn_state;
  } arf_result_t;

  localparam arf_cfg_t CFG_RESET = '{
    retry_interval: 16'd2,
    retry_limit:    16'd15,
    lifetime:       16'd4,
    agent_is_aa:    1'b0
  };

  localparam arf_state_t ST_RESET = '{
    phase:            PH_IDLE,
    agent_high:       '0,
    agent_low:        '0,
    agent_port:       '0,
    next_high:        '0,
    next_low:         '0,
    next_port:        '0,
    next_waiting:     1'b0,
    current_xid:      '0,
    elapsed_retry:    '0,
    release_pending:  1'b0,
    timer_uses_retry: 1'b0
  };

  function automatic logic [STATE_W-1:0] phase_code(input phase_t ph);
    logic [STATE_W-1:0] c;
    case (ph)
      PH_IDLE: c = CODE_IDLE;
      PH_WREG: c = CODE_WREG;
      PH_DONE: c = CODE_DONE;
      default: c = CODE_WUNREG;
    endcase
    return c;
  endfunction

  // max(1, floor(lifetime * 3 / 4))
  function automatic logic [TIME_W-1:0] resend_interval(input logic [TIME_W-1:0] lt);
    logic [TIME_W+1:0] m;
    logic [TIME_W-1:0] v;
    m = {2'b00, lt} + {1'b0, lt, 1'b0};
    v = m[TIME_W+1:2];
    return (v == '0) ? TIME_W'(1) : v;
  endfunction

endpackage

### rtl/arf_if.sv
// Valid/ready channel interfaces for the event and result transactions.
// Depends on arf_pkg for field widths.
interface arf_in_if;
  logic                      valid;
  logic                      ready;
  logic [arf_pkg::CMD_W-1:0]  command;
  logic [arf_pkg::ADDR_W-1:0] addr_high;
  logic [arf_pkg::ADDR_W-1:0] addr_low;
  logic [arf_pkg::PORT_W-1:0] addr_port;
  logic [arf_pkg::XID_W-1:0]  ack_xid;
  logic [arf_pkg::XID_W-1:0]  fresh_xid;

  modport source (output valid, command, addr_high, addr_low, addr_port, ack_xid, fresh_xid,
                  input ready);
  modport sink (input valid, command, addr_high, addr_low, addr_port, ack_xid, fresh_xid,
                output ready);
endinterface

interface arf_out_if;
  logic                        valid;
  logic                        ready;
  logic [arf_pkg::SEND_W-1:0]  send_kind;
  logic [arf_pkg::ADDR_W-1:0]  dest_high;
  logic [arf_pkg::ADDR_W-1:0]  dest_low;
  logic [arf_pkg::PORT_W-1:0]  dest_port;
  logic [arf_pkg::XID_W-1:0]   send_xid;
  logic [arf_pkg::TMR_W-1:0]   timer_action;
  logic [arf_pkg::TIME_W-1:0]  timer_interval;
  logic                        release_notice;
  logic [arf_pkg::STATE_W-1:0] conn_state;

  modport source (output valid, send_kind, dest_high, dest_low, dest_port, send_xid,
                  timer_action, timer_interval, release_notice, conn_state,
                  input ready);
  modport sink (input valid, send_kind, dest_high, dest_low, dest_port, send_xid,
                timer_action, timer_interval, release_notice, conn_state,
                output ready);
endinterface

### rtl/arf_core.sv
// Next-state and result decision for one event transaction.
// Depends on arf_pkg for state, event, result and configuration types.
module arf_core (
  input  arf_pkg::arf_cfg_t    cfg,
  input  arf_pkg::arf_state_t  st,
  input  arf_pkg::arf_event_t  ev,
  output arf_pkg::arf_state_t  st_nxt,
  output arf_pkg::arf_result_t res
);
  import arf_pkg::*;

  logic              same_agent;
  logic              wrong_kind;
  logic              xid_hit;
  logic [TIME_W:0]   elapsed_sum;
  logic [TIME_W-1:0] elapsed_sat;
  logic              over_limit;

  assign same_agent = (ev.addr_high == st.agent_high) && (ev.addr_low == st.agent_low) &&
                      (ev.addr_port == st.agent_port);
  assign wrong_kind = (cfg.agent_is_aa && (ev.command == CMD_DA)) ||
                      (!cfg.agent_is_aa && (ev.command == CMD_AA));
  assign xid_hit     = (ev.ack_xid == st.current_xid);
  assign elapsed_sum = {1'b0, st.elapsed_retry} + {1'b0, cfg.retry_interval};
  assign elapsed_sat = elapsed_sum[TIME_W] ? '1 : elapsed_sum[TIME_W-1:0];
  assign over_limit  = (elapsed_sat > cfg.retry_limit);

  always_comb begin
    st_nxt = st;
    res = '0;
    res.send_kind = SEND_NONE;
    res.timer_action = TMR_LEAVE;

    case (ev.command)
      CMD_AA, CMD_DA: begin
        if (st.phase == PH_IDLE) begin
          st_nxt.agent_high = ev.addr_high;
          st_nxt.agent_low = ev.addr_low;
          st_nxt.agent_port = ev.addr_port;
          st_nxt.current_xid = ev.fresh_xid;
          st_nxt.elapsed_retry = '0;
          st_nxt.phase = PH_WREG;
          st_nxt.timer_uses_retry = 1'b1;
          res.send_kind = SEND_REG;
          res.timer_action = TMR_START;
        end else if (!wrong_kind && !same_agent) begin
          st_nxt.next_high = ev.addr_high;
          st_nxt.next_low = ev.addr_low;
          st_nxt.next_port = ev.addr_port;
          st_nxt.next_waiting = 1'b1;
          if (st.phase != PH_WUNREG) begin
            st_nxt.elapsed_retry = '0;
            st_nxt.current_xid = ev.fresh_xid;
            st_nxt.phase = PH_WUNREG;
            st_nxt.timer_uses_retry = 1'b1;
            res.send_kind = SEND_DEREG;
            res.timer_action = TMR_START;
          end
        end
      end
      CMD_ACK: begin
        if ((st.phase == PH_WREG) || (st.phase == PH_WUNREG)) begin
          if (!xid_hit) begin
            res.timer_action = TMR_START;
          end else if (same_agent) begin
            res.timer_action = TMR_START;
            if (st.phase == PH_WREG) begin
              st_nxt.current_xid = '0;
              st_nxt.phase = PH_DONE;
              st_nxt.timer_uses_retry = 1'b0;
            end else if (st.release_pending) begin
              st_nxt.current_xid = '0;
              st_nxt.release_pending = 1'b0;
              st_nxt.next_high = '0;
              st_nxt.next_low = '0;
              st_nxt.next_port = '0;
              st_nxt.next_waiting = 1'b0;
              st_nxt.elapsed_retry = '0;
              st_nxt.phase = PH_IDLE;
              st_nxt.timer_uses_retry = 1'b0;
              res.release_notice = 1'b1;
              res.timer_action = TMR_LEAVE;
            end else if (st.next_waiting) begin
              st_nxt.elapsed_retry = '0;
              st_nxt.agent_high = st.next_high;
              st_nxt.agent_low = st.next_low;
              st_nxt.agent_port = st.next_port;
              st_nxt.next_high = '0;
              st_nxt.next_low = '0;
              st_nxt.next_port = '0;
              st_nxt.next_waiting = 1'b0;
              st_nxt.current_xid = ev.fresh_xid;
              st_nxt.phase = PH_WREG;
              st_nxt.timer_uses_retry = 1'b1;
              res.send_kind = SEND_REG;
            end else begin
              st_nxt.current_xid = '0;
              st_nxt.phase = PH_IDLE;
              st_nxt.timer_uses_retry = 1'b0;
            end
          end
        end
      end
      CMD_MOVE: begin
        if ((st.phase == PH_WREG) || (st.phase == PH_DONE)) begin
          st_nxt.current_xid = ev.fresh_xid;
          st_nxt.phase = PH_WUNREG;
          st_nxt.timer_uses_retry = 1'b1;
          res.send_kind = SEND_DEREG;
          res.timer_action = TMR_START;
        end
      end
      CMD_EXPIRE: begin
        if (st.phase == PH_DONE) begin
          st_nxt.current_xid = ev.fresh_xid;
          st_nxt.elapsed_retry = '0;
          st_nxt.phase = PH_WREG;
          st_nxt.timer_uses_retry = 1'b1;
          res.send_kind = SEND_REG;
          res.timer_action = TMR_START;
        end else if (st.phase != PH_IDLE) begin
          st_nxt.elapsed_retry = elapsed_sat;
          if (!over_limit) begin
            res.send_kind = (st.phase == PH_WREG) ? SEND_REG : SEND_DEREG;
            res.timer_action = TMR_START;
          end else begin
            st_nxt.elapsed_retry = '0;
            st_nxt.current_xid = '0;
            if (st.release_pending) begin
              st_nxt.release_pending = 1'b0;
              st_nxt.next_high = '0;
              st_nxt.next_low = '0;
              st_nxt.next_port = '0;
              st_nxt.next_waiting = 1'b0;
              st_nxt.phase = PH_IDLE;
              st_nxt.timer_uses_retry = 1'b0;
              res.release_notice = 1'b1;
            end else if ((st.phase == PH_WUNREG) && st.next_waiting) begin
              st_nxt.agent_high = st.next_high;
              st_nxt.agent_low = st.next_low;
              st_nxt.agent_port = st.next_port;
              st_nxt.next_high = '0;
              st_nxt.next_low = '0;
              st_nxt.next_port = '0;
              st_nxt.next_waiting = 1'b0;
              st_nxt.current_xid = ev.fresh_xid;
              st_nxt.phase = PH_WREG;
              res.send_kind = SEND_REG;
              res.timer_action = TMR_START;
            end else begin
              st_nxt.timer_uses_retry = 1'b0;
              st_nxt.phase = PH_IDLE;
              res.timer_action = TMR_STOP;
            end
          end
        end
      end
      CMD_RELEASE: begin
        if (st.phase == PH_IDLE) begin
          st_nxt.current_xid = '0;
          res.release_notice = 1'b1;
        end else if (st.phase == PH_WREG) begin
          st_nxt.release_pending = 1'b1;
        end else begin
          st_nxt.current_xid = ev.fresh_xid;
          st_nxt.phase = PH_WUNREG;
          st_nxt.timer_uses_retry = 1'b1;
          st_nxt.release_pending = 1'b1;
          res.send_kind = SEND_DEREG;
          res.timer_action = TMR_START;
        end
      end
      default: begin
      end
    endcase

    if (res.send_kind != SEND_NONE) begin
      res.dest_high = st_nxt.agent_high;
      res.dest_low = st_nxt.agent_low;
      res.dest_port = st_nxt.agent_port;
      res.send_xid = st_nxt.current_xid;
    end
    res.timer_interval = st_nxt.timer_uses_retry ? cfg.retry_interval
                                                 : resend_interval(cfg.lifetime);
    res.conn_state = phase_code(st_nxt.phase);
  end

endmodule

### rtl/agent_registration_fsm.sv
// Agent registration connection: top level with state, configuration and result registers.
// Depends on arf_pkg, arf_if.sv and arf_core.sv.
//
// Takes one event transaction per clock and returns exactly one result transaction for it
// from a registered output stage. The decision is a single pass of arf_core over the state
// registers, so a new event is taken in every cycle as long as the result register is empty
// or is being drained in the same cycle. Configuration writes land on the next edge and are
// used by the following events.
module agent_registration_fsm (
  input  logic                            clk,
  input  logic                            rst_n,
  arf_in_if.sink                          in_chan,
  arf_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [arf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [arf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import arf_pkg::*;

  arf_cfg_t    cfg_r;
  arf_state_t  st_r;
  arf_state_t  st_nxt;
  arf_event_t  ev;
  arf_result_t res_nxt;
  arf_result_t res_r;
  logic        out_valid_r;
  logic        in_fire;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_fire = in_chan.valid && in_chan.ready;

  assign ev.command   = in_chan.command;
  assign ev.addr_high = in_chan.addr_high;
  assign ev.addr_low  = in_chan.addr_low;
  assign ev.addr_port = in_chan.addr_port;
  assign ev.ack_xid   = in_chan.ack_xid;
  assign ev.fresh_xid = in_chan.fresh_xid;

  arf_core u_core (
    .cfg    (cfg_r),
    .st     (st_r),
    .ev     (ev),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RETRY_INTERVAL: cfg_r.retry_interval <= cfg_wdata[TIME_W-1:0];
        CFG_RETRY_LIMIT:    cfg_r.retry_limit <= cfg_wdata[TIME_W-1:0];
        CFG_LIFETIME:       cfg_r.lifetime <= cfg_wdata[TIME_W-1:0];
        CFG_AGENT_IS_AA:    cfg_r.agent_is_aa <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.send_kind      = res_r.send_kind;
  assign out_chan.dest_high      = res_r.dest_high;
  assign out_chan.dest_low       = res_r.dest_low;
  assign out_chan.dest_port      = res_r.dest_port;
  assign out_chan.send_xid       = res_r.send_xid;
  assign out_chan.timer_action   = res_r.timer_action;
  assign out_chan.timer_interval = res_r.timer_interval;
  assign out_chan.release_notice = res_r.release_notice;
  assign out_chan.conn_state     = res_r.conn_state;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_send_starts_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.send_kind != SEND_NONE)) |-> (res_r.timer_action == TMR_START))
    else $error("send without timer start");

  a_release_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.release_notice) |-> (res_r.conn_state == CODE_IDLE))
    else $error("release notice outside idle");

  a_registered_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.conn_state == CODE_DONE)) |-> (res_r.send_kind == SEND_NONE))
    else $error("send while entering registered state");

  a_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_r.conn_state == phase_code(st_r.phase)))
    else $error("result state differs from held state");

endmodule
